// ----- design/imh_pkg.sv -----
// Shared types, codes and constants for the indexed min-heap queue.
package imh_pkg;

  localparam int DefNumIds = 64;
  localparam int IdW       = 6;
  localparam int KeyW      = 32;

  typedef enum logic [1:0] {
    OP_INSERT  = 2'd0,
    OP_EXTRACT = 2'd1,
    OP_REMOVE  = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_FULL    = 3'd1,
    ST_EMPTY   = 3'd2,
    ST_ABSENT  = 3'd3,
    ST_PRESENT = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_POS_CHK,
    S_LAST_LD,
    S_UP_RD,
    S_UP_CMP,
    S_DN_RD,
    S_DN_LEFT,
    S_DN_SEL,
    S_DN_CMP,
    S_PLACE,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]             opcode;
    logic [IdW-1:0]         proc_id;
    logic signed [KeyW-1:0] prio_key;
  } in_word_t;

  typedef struct packed {
    logic [2:0]             result_status;
    logic [IdW-1:0]         result_id;
    logic signed [KeyW-1:0] min_key;
    logic                   heap_empty;
    logic [5:0]             entry_count;
  } out_word_t;

  typedef struct packed {
    logic [IdW-1:0]         id;
    logic signed [KeyW-1:0] key;
  } entry_t;

endpackage

// ----- design/imh_ram.sv -----
// Simple dual-port RAM with one write port and one registered read port.
module imh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/indexed_min_heap_queue.sv -----
// Top level: indexed binary min-heap queue with its sift sequencer.
//
// Indexed binary min-heap of (id, signed key) entries with a per-id slot table.
// One word is taken at a time; in_ready is high only while the sequencer is idle.
// A rejected or trivial word goes from execute straight to done. Insert reads and
// compares the parent per level climbed; extract does left read, right read, child
// select and compare per level descended; remove checks the slot, loads the last
// entry, then climbs or descends. The pace is set by the single read port of the
// heap RAM and the one shared key comparator. The heap holds NUM_IDS-1 entries.
module indexed_min_heap_queue
  import imh_pkg::*;
#(
  parameter int NUM_IDS = DefNumIds
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  localparam int HW = $clog2(NUM_IDS);
  localparam int EW = IdW + KeyW;

  state_t state, state_next;

  op_t                    op_r;
  logic [IdW-1:0]         id_r;
  logic signed [KeyW-1:0] key_r;
  entry_t                 cur;
  entry_t                 lreg;
  entry_t                 child;
  entry_t                 root;
  logic [HW-1:0]          hole;
  logic [HW-1:0]          child_idx;
  logic [HW-1:0]          size;
  logic                   moved;
  logic                   have_r;
  logic [NUM_IDS-1:0]     present;
  status_t                status_r;
  logic [IdW-1:0]         rid_r;

  logic                   heap_we;
  logic [HW-1:0]          heap_waddr;
  entry_t                 heap_wdata;
  logic [HW-1:0]          heap_raddr;
  logic [EW-1:0]          heap_rbits;
  entry_t                 rd;
  logic                   pos_we;
  logic [HW-1:0]          pos_waddr;
  logic [HW-1:0]          pos_wdata;
  logic [HW-1:0]          pos_raddr;
  logic [HW-1:0]          pos_rd;

  logic signed [KeyW-1:0] cmp_a, cmp_b;
  logic                   cmp_lt;

  logic [HW:0]            left_idx, right_idx, size_x;
  logic [HW-1:0]          parent_idx;
  logic [HW-1:0]          id_idx;
  logic                   id_ok;
  logic [HW-1:0]          size_m1;

  function automatic logic [HW-1:0] idx_of(input logic [IdW-1:0] v);
    logic [31:0] t;
    t = 32'(v);
    return t[HW-1:0];
  endfunction

  assign rd         = entry_t'(heap_rbits);
  assign id_idx     = idx_of(id_r);
  assign id_ok      = 32'(id_r) < 32'(NUM_IDS);
  assign size_m1    = size - 1'b1;
  assign size_x     = {1'b0, size};
  assign left_idx   = {hole, 1'b1};
  assign right_idx  = left_idx + 1'b1;
  assign parent_idx = HW'((hole - 1'b1) >> 1);

  // Shared key comparator.
  assign cmp_lt = cmp_a < cmp_b;

  imh_ram #(.WIDTH(EW), .DEPTH(NUM_IDS)) u_heap (
    .clk   (clk),
    .we    (heap_we),
    .waddr (heap_waddr),
    .wdata (heap_wdata),
    .raddr (heap_raddr),
    .rdata (heap_rbits)
  );

  imh_ram #(.WIDTH(HW), .DEPTH(NUM_IDS)) u_pos (
    .clk   (clk),
    .we    (pos_we),
    .waddr (pos_waddr),
    .wdata (pos_wdata),
    .raddr (pos_raddr),
    .rdata (pos_rd)
  );

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        unique case (op_r)
          OP_INSERT: begin
            if (id_ok && !present[id_idx] && (32'(size) < 32'(NUM_IDS - 1))) begin
              state_next = S_UP_RD;
            end else begin
              state_next = S_DONE;
            end
          end
          OP_EXTRACT: begin
            state_next = (size > HW'(1)) ? S_LAST_LD : S_DONE;
          end
          OP_REMOVE: begin
            state_next = (id_ok && present[id_idx]) ? S_POS_CHK : S_DONE;
          end
          default: state_next = S_DONE;
        endcase
      end
      // size already holds the shrunk count, so it indexes the last entry
      S_POS_CHK: state_next = (pos_rd < size) ? S_LAST_LD : S_DONE;
      S_LAST_LD: state_next = (op_r == OP_EXTRACT) ? S_DN_RD : S_UP_RD;
      S_UP_RD: begin
        if (hole != '0) begin
          state_next = S_UP_CMP;
        end else begin
          state_next = (op_r == OP_REMOVE && !moved) ? S_DN_RD : S_PLACE;
        end
      end
      S_UP_CMP: begin
        if (cmp_lt) begin
          state_next = S_UP_RD;
        end else begin
          state_next = (op_r == OP_REMOVE && !moved) ? S_DN_RD : S_PLACE;
        end
      end
      S_DN_RD:   state_next = (left_idx < size_x) ? S_DN_LEFT : S_PLACE;
      S_DN_LEFT: state_next = S_DN_SEL;
      S_DN_SEL:  state_next = S_DN_CMP;
      S_DN_CMP:  state_next = cmp_lt ? S_DN_RD : S_PLACE;
      S_PLACE:   state_next = S_DONE;
      S_DONE: begin
        if (!out_valid || out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Memory ports and comparator operands.
  always_comb begin
    heap_we    = 1'b0;
    heap_waddr = hole;
    heap_wdata = cur;
    heap_raddr = size_m1;
    pos_we     = 1'b0;
    pos_waddr  = idx_of(cur.id);
    pos_wdata  = hole;
    pos_raddr  = id_idx;
    cmp_a      = cur.key;
    cmp_b      = rd.key;
    unique case (state)
      S_POS_CHK: heap_raddr = size;
      S_UP_RD: heap_raddr = parent_idx;
      S_UP_CMP: begin
        if (cmp_lt) begin
          heap_we    = 1'b1;
          heap_wdata = rd;
          pos_we     = 1'b1;
          pos_waddr  = idx_of(rd.id);
        end
      end
      S_DN_RD:   heap_raddr = left_idx[HW-1:0];
      S_DN_LEFT: heap_raddr = right_idx[HW-1:0];
      S_DN_SEL: begin
        cmp_a = rd.key;
        cmp_b = lreg.key;
      end
      S_DN_CMP: begin
        cmp_a = child.key;
        cmp_b = cur.key;
        if (cmp_lt) begin
          heap_we    = 1'b1;
          heap_wdata = child;
          pos_we     = 1'b1;
          pos_waddr  = idx_of(child.id);
        end
      end
      S_PLACE: begin
        heap_we = 1'b1;
        pos_we  = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Sequencer registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      size      <= '0;
      present   <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_valid && out_ready && state != S_DONE) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            op_r  <= op_t'(in_data.opcode);
            id_r  <= in_data.proc_id;
            key_r <= in_data.prio_key;
          end
        end
        S_EXEC: begin
          moved <= 1'b0;
          unique case (op_r)
            OP_INSERT: begin
              rid_r <= id_r;
              if (!id_ok) begin
                status_r <= ST_ABSENT;
              end else if (present[id_idx]) begin
                status_r <= ST_PRESENT;
              end else if (32'(size) >= 32'(NUM_IDS - 1)) begin
                status_r <= ST_FULL;
              end else begin
                status_r         <= ST_OK;
                cur.id           <= id_r;
                cur.key          <= key_r;
                hole             <= size;
                size             <= size + 1'b1;
                present[id_idx]  <= 1'b1;
              end
            end
            OP_EXTRACT: begin
              if (size == '0) begin
                status_r <= ST_EMPTY;
                rid_r    <= '0;
              end else begin
                status_r                 <= ST_OK;
                rid_r                    <= root.id;
                present[idx_of(root.id)] <= 1'b0;
                size                     <= size_m1;
                hole                     <= '0;
              end
            end
            OP_REMOVE: begin
              rid_r <= id_r;
              if (!(id_ok && present[id_idx])) begin
                status_r <= ST_ABSENT;
              end else begin
                status_r        <= ST_OK;
                present[id_idx] <= 1'b0;
                size            <= size_m1;
              end
            end
            default: begin
              status_r <= ST_OK;
              rid_r    <= '0;
            end
          endcase
        end
        S_POS_CHK: hole <= pos_rd;
        S_LAST_LD: cur  <= rd;
        S_UP_CMP: begin
          if (cmp_lt) begin
            hole  <= parent_idx;
            moved <= 1'b1;
          end
        end
        S_DN_LEFT: begin
          lreg   <= rd;
          have_r <= right_idx < size_x;
        end
        S_DN_SEL: begin
          if (have_r && cmp_lt) begin
            child     <= rd;
            child_idx <= right_idx[HW-1:0];
          end else begin
            child     <= lreg;
            child_idx <= left_idx[HW-1:0];
          end
        end
        S_DN_CMP: begin
          if (cmp_lt) hole <= child_idx;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid              <= 1'b1;
            out_data.result_status <= status_r;
            out_data.result_id     <= rid_r;
            out_data.min_key       <= (size != '0) ? root.key : '0;
            out_data.heap_empty    <= (size == '0);
            out_data.entry_count   <= 6'(size);
          end
        end
        default: begin
        end
      endcase
      // Track the root entry for extract and the reported minimum.
      if (heap_we && heap_waddr == '0) root <= heap_wdata;
    end
  end

  assign in_ready = (state == S_IDLE);

`ifndef SYNTH
  a_size_cap: assert property (@(posedge clk) disable iff (rst)
    32'(size) <= 32'(NUM_IDS - 1))
    else $error("heap size above capacity");

  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == S_EXEC)
    else $error("accepted word not executed");

  a_empty_key: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.heap_empty |-> out_data.min_key == '0)
    else $error("empty heap reports nonzero key");
`endif

endmodule

// ----- tb/indexed_min_heap_queue_tb.sv -----
// Testbench for the indexed min-heap queue: directed table, then random words checked by a heap model.
`timescale 1ns / 1ps

module indexed_min_heap_queue_tb;
  import imh_pkg::*;

  localparam int Capacity   = DefNumIds - 1;
  localparam int CycleLimit = 1500000;

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_ready;
  in_word_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_word_t out_data;

  indexed_min_heap_queue u_top (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // heap model state
  entry_t          heap_mem [DefNumIds];
  int              slot_of  [DefNumIds];
  bit              id_live  [DefNumIds];
  int              heap_cnt;
  out_word_t       pending_results[$];

  int  errors;
  int  cycles;
  int  send_idle_pct;
  int  recv_idle_pct;
  bit  recv_hold;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic void place_entry(int at, entry_t e);
    heap_mem[at] = e;
    slot_of[e.id] = at;
  endfunction

  function automatic void swap_entries(int a, int b);
    entry_t t;
    t = heap_mem[a];
    place_entry(a, heap_mem[b]);
    place_entry(b, t);
  endfunction

  function automatic void climb(int i);
    int p;
    while (i > 0) begin
      p = (i - 1) / 2;
      if (heap_mem[i].key < heap_mem[p].key) begin
        swap_entries(i, p);
        i = p;
      end else begin
        break;
      end
    end
  endfunction

  function automatic void descend(int i);
    int l;
    int c;
    forever begin
      l = 2 * i + 1;
      if (l >= heap_cnt) break;
      c = l;
      if (l + 1 < heap_cnt && heap_mem[l + 1].key < heap_mem[l].key) c = l + 1;
      if (heap_mem[i].key > heap_mem[c].key) begin
        swap_entries(i, c);
        i = c;
      end else begin
        break;
      end
    end
  endfunction

  function automatic out_word_t apply_word(in_word_t w);
    out_word_t r;
    entry_t    e;
    int        at;
    r = '0;
    r.result_status = ST_OK;
    case (op_t'(w.opcode))
      OP_INSERT: begin
        r.result_id = w.proc_id;
        if (id_live[w.proc_id]) begin
          r.result_status = ST_PRESENT;
        end else if (heap_cnt >= Capacity) begin
          r.result_status = ST_FULL;
        end else begin
          e.id = w.proc_id;
          e.key = w.prio_key;
          place_entry(heap_cnt, e);
          id_live[w.proc_id] = 1'b1;
          heap_cnt++;
          climb(heap_cnt - 1);
        end
      end
      OP_EXTRACT: begin
        if (heap_cnt == 0) begin
          r.result_status = ST_EMPTY;
        end else begin
          r.result_id = heap_mem[0].id;
          id_live[heap_mem[0].id] = 1'b0;
          heap_cnt--;
          if (heap_cnt > 0) begin
            place_entry(0, heap_mem[heap_cnt]);
            descend(0);
          end
        end
      end
      OP_REMOVE: begin
        r.result_id = w.proc_id;
        if (!id_live[w.proc_id]) begin
          r.result_status = ST_ABSENT;
        end else begin
          at = slot_of[w.proc_id];
          id_live[w.proc_id] = 1'b0;
          heap_cnt--;
          if (at < heap_cnt) begin
            place_entry(at, heap_mem[heap_cnt]);
            climb(at);
            descend(at);
          end
        end
      end
      default: ;
    endcase
    r.min_key = heap_cnt > 0 ? heap_mem[0].key : '0;
    r.heap_empty = heap_cnt == 0;
    r.entry_count = heap_cnt[5:0];
    return r;
  endfunction

  // predict on each accepted word, check each accepted result
  always @(posedge clk) begin
    out_word_t exp_r;
    if (!rst) begin
      if (in_valid && in_ready) pending_results.push_back(apply_word(in_data));
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result %h", $time, out_data);
          errors++;
        end else begin
          exp_r = pending_results.pop_front();
          if (out_data.result_status !== exp_r.result_status) begin
            $display("%0t: status exp %0d got %0d", $time, exp_r.result_status,
                     out_data.result_status);
            errors++;
          end
          if (out_data.result_id !== exp_r.result_id) begin
            $display("%0t: id exp %0d got %0d", $time, exp_r.result_id,
                     out_data.result_id);
            errors++;
          end
          if (out_data.min_key !== exp_r.min_key) begin
            $display("%0t: min_key exp %0d got %0d", $time, exp_r.min_key,
                     out_data.min_key);
            errors++;
          end
          if (out_data.heap_empty !== exp_r.heap_empty) begin
            $display("%0t: empty exp %0d got %0d", $time, exp_r.heap_empty,
                     out_data.heap_empty);
            errors++;
          end
          if (out_data.entry_count !== exp_r.entry_count) begin
            $display("%0t: count exp %0d got %0d", $time, exp_r.entry_count,
                     out_data.entry_count);
            errors++;
          end
        end
      end
    end
  end

  // receiver: random stalls, or a held-off stretch
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (recv_hold) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // long receiver hold-off, counted here
  initial begin
    recv_hold = 1'b0;
    @(negedge rst);
    repeat (3000) @(posedge clk);
    recv_hold = 1'b1;
    repeat (400) @(posedge clk);
    recv_hold = 1'b0;
  end

  // hold valid across back-to-back words; drop it only while idling
  task automatic send_word(logic [1:0] op, logic [5:0] id, logic [31:0] key);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= {op, id, key};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  typedef struct {
    op_t         op;
    logic [5:0]  id;
    logic [31:0] key;
    bit          typed;
    status_t     st;
  } stim_row_t;

  stim_row_t directed_rows[] = '{
    '{OP_EXTRACT, 6'd0,  32'h0,        1'b1, ST_EMPTY},
    '{OP_REMOVE,  6'd63, 32'h0,        1'b1, ST_ABSENT},
    '{OP_NONE,    6'd5,  32'h12345678, 1'b1, ST_OK},
    '{OP_INSERT,  6'd63, 32'h7FFFFFFF, 1'b1, ST_OK},
    '{OP_INSERT,  6'd63, 32'h0,        1'b1, ST_PRESENT},
    '{OP_INSERT,  6'd0,  32'h80000000, 1'b1, ST_OK},
    '{OP_INSERT,  6'd1,  32'h80000000, 1'b0, ST_OK},
    '{OP_INSERT,  6'd2,  32'hFFFFFFFF, 1'b0, ST_OK},
    '{OP_INSERT,  6'd3,  32'h00000001, 1'b0, ST_OK},
    '{OP_INSERT,  6'd42, 32'h00000000, 1'b0, ST_OK},
    '{OP_REMOVE,  6'd1,  32'h0,        1'b0, ST_OK},
    '{OP_REMOVE,  6'd42, 32'h0,        1'b0, ST_OK},
    '{OP_REMOVE,  6'd1,  32'h0,        1'b1, ST_ABSENT},
    '{OP_EXTRACT, 6'd0,  32'h0,        1'b0, ST_OK},
    '{OP_EXTRACT, 6'd0,  32'h0,        1'b0, ST_OK},
    '{OP_EXTRACT, 6'd0,  32'h0,        1'b0, ST_OK},
    '{OP_EXTRACT, 6'd0,  32'h0,        1'b0, ST_OK},
    '{OP_EXTRACT, 6'd0,  32'h0,        1'b1, ST_EMPTY}
  };

  // typed statuses must agree with the model for the table rows
  task automatic run_table();
    out_word_t chk;
    foreach (directed_rows[i]) begin
      send_word(directed_rows[i].op, directed_rows[i].id, directed_rows[i].key);
      in_valid <= 1'b0;
      // wait on the clock so the prediction for this word is queued
      @(posedge clk);
      chk = pending_results[$];
      if (directed_rows[i].typed && chk.result_status !== directed_rows[i].st) begin
        $display("%0t: row %0d status exp %0d got %0d", $time, i,
                 directed_rows[i].st, chk.result_status);
        errors++;
      end
    end
  endtask

  task automatic random_phase(int n);
    int          r;
    logic [1:0]  op;
    logic [31:0] key;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(99);
      // lean on inserts while small, extracts/removes while large
      if (r < (heap_cnt < 40 ? 55 : 30)) op = OP_INSERT;
      else if (r < 75) op = OP_EXTRACT;
      else if (r < 97) op = OP_REMOVE;
      else op = OP_NONE;
      case ($urandom_range(3))
        0: key = $urandom_range(7);
        1: key = {$urandom_range(1) ? 2'b10 : 2'b01, 30'($urandom)};
        default: key = $urandom;
      endcase
      send_word(op, 6'($urandom_range(63)), key);
    end
  endtask

  initial begin
    errors = 0;
    cycles = 0;
    heap_cnt = 0;
    foreach (id_live[i]) id_live[i] = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    send_idle_pct = 17;
    recv_idle_pct = 58;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    run_table();
    // fill to capacity so full is reached
    for (int i = 0; i < DefNumIds; i++) send_word(OP_INSERT, 6'(i), $urandom);
    drain_results();
    random_phase(500);
    send_idle_pct = 58;
    recv_idle_pct = 17;
    random_phase(500);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(450);
    drain_results();
    repeat (100) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/imh_pkg.sv
design/imh_ram.sv
design/indexed_min_heap_queue.sv
tb/indexed_min_heap_queue_tb.sv
